[hw/rtl/cmfr_pkg.sv]
// Package for the CAN multi-frame reassembler: field widths, register indexes,
// default parameter values and the match record passed from the topic matcher.
// No dependencies.
`timescale 1ns / 1ps

package cmfr_pkg;

    // Defaults for the top-level parameters.
    localparam int TOPICS_DEF        = 4;
    localparam int MAX_FRAMES_DEF    = 16;
    localparam int MAX_MSG_BYTES_DEF = 128;

    // Bytes carried by one CAN frame and by one message word.
    localparam int WORD_BYTES = 8;

    // Frame and result field widths.
    localparam int CAN_ID_W    = 11;
    localparam int DLC_W       = 4;
    localparam int DATA_W      = 64;
    localparam int TICK_W      = 32;
    localparam int OUT_TOPIC_W = 2;
    localparam int OUT_WORD_W  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SETUP_W    = 20;
    localparam int GAP_W      = 16;
    localparam int SETUP_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TOPIC_SETUP0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT  = 3'd4;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd100;

    // Widths of the match record, sized for the largest parameter values.
    localparam int TOPIC_SEL_W = 3;
    localparam int FRAME_SEL_W = 4;
    localparam int FRAME_CNT_W = 5;
    localparam int MSG_BYTES_W = 8;
    localparam int CHUNK_W     = 4;

    typedef struct packed {
        logic                   hit;
        logic [TOPIC_SEL_W-1:0] topic;
        logic [FRAME_SEL_W-1:0] frame;
        logic [MSG_BYTES_W-1:0] msg_bytes;
        logic [FRAME_CNT_W-1:0] frames;
        logic [CHUNK_W-1:0]     chunk;
    } t_match;

endpackage

[hw/rtl/cmfr_frame_if.sv]
// Input channel carrying one received CAN frame per beat.
// Depends on cmfr_pkg for the field widths.
`timescale 1ns / 1ps

interface cmfr_frame_if import cmfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CAN_ID_W-1:0] can_id;
    logic [DLC_W-1:0]    byte_count;
    logic [DATA_W-1:0]   payload;
    logic [TICK_W-1:0]   now_ms;

    modport source (output valid, can_id, byte_count, payload, now_ms, input ready);
    modport sink   (input valid, can_id, byte_count, payload, now_ms, output ready);
endinterface

[hw/rtl/cmfr_word_if.sv]
// Output channel carrying one 8-byte word of a completed message per beat.
// Depends on cmfr_pkg for the field widths.
`timescale 1ns / 1ps

interface cmfr_word_if import cmfr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUT_TOPIC_W-1:0] topic_index;
    logic [OUT_WORD_W-1:0]  word_index;
    logic [DATA_W-1:0]      word_data;
    logic [DLC_W-1:0]       word_bytes;
    logic                   last_word;

    modport source (output valid, topic_index, word_index, word_data, word_bytes, last_word,
                    input ready);
    modport sink   (input valid, topic_index, word_index, word_data, word_bytes, last_word,
                    output ready);
endinterface

[hw/rtl/cmfr_match.sv]
// Topic matcher: finds the first enabled topic whose identifier run holds the
// frame and works out the frame's offset and the number of bytes to store.
// Depends on cmfr_pkg.
`timescale 1ns / 1ps

module cmfr_match import cmfr_pkg::*; #(
    parameter int TOPICS        = TOPICS_DEF,
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic [SETUP_W-1:0]  i_setup [TOPICS],
    input  logic [CAN_ID_W-1:0] i_can_id,
    input  logic [DLC_W-1:0]    i_byte_count,
    output t_match              o_match
);

    logic [TOPICS-1:0] hit;
    logic [FRAME_SEL_W-1:0] fi    [TOPICS];
    logic [MSG_BYTES_W-1:0] bytes [TOPICS];
    logic [FRAME_CNT_W-1:0] nf    [TOPICS];
    logic [CHUNK_W-1:0]     chunk [TOPICS];
    logic [DLC_W-1:0]       dlc_clip;

    // A length code above eight still carries only eight bytes.
    assign dlc_clip = (i_byte_count > DLC_W'(WORD_BYTES)) ? DLC_W'(WORD_BYTES) : i_byte_count;

    for (genvar t = 0; t < TOPICS; t++) begin : g_topic
        logic [MSG_BYTES_W-1:0] raw_bytes;
        logic [MSG_BYTES_W:0]   nf_raw;
        logic [CAN_ID_W-1:0]    base;
        logic [CAN_ID_W:0]      run_end;
        logic [CAN_ID_W:0]      rel;
        logic [MSG_BYTES_W-1:0] rem;
        logic [CHUNK_W-1:0]     room;

        assign raw_bytes = i_setup[t][18:11];
        assign bytes[t]  = (raw_bytes > MSG_BYTES_W'(MAX_MSG_BYTES)) ?
                           MSG_BYTES_W'(MAX_MSG_BYTES) : raw_bytes;
        assign nf_raw    = ({1'b0, bytes[t]} + 9'd7) >> 3;
        assign nf[t]     = (nf_raw > 9'(MAX_FRAMES)) ? FRAME_CNT_W'(MAX_FRAMES) :
                           nf_raw[FRAME_CNT_W-1:0];
        assign base      = i_setup[t][10:0];
        assign run_end   = {1'b0, base} + 12'(nf[t]);
        assign rel       = {1'b0, i_can_id} - {1'b0, base};
        assign hit[t]    = i_setup[t][19] && (i_can_id >= base) && ({1'b0, i_can_id} < run_end);
        assign fi[t]     = rel[FRAME_SEL_W-1:0];
        // Bytes left in the message from this frame's offset on.
        assign rem       = bytes[t] - {1'b0, fi[t], 3'b000};
        assign room      = (rem >= MSG_BYTES_W'(WORD_BYTES)) ? CHUNK_W'(WORD_BYTES) :
                           rem[CHUNK_W-1:0];
        assign chunk[t]  = (dlc_clip < room) ? dlc_clip : room;
    end

    // Lower topic indexes take priority, so the scan runs downwards.
    always_comb begin
        o_match = '0;
        for (int t = TOPICS - 1; t >= 0; t--) begin
            if (hit[t]) begin
                o_match.hit       = 1'b1;
                o_match.topic     = TOPIC_SEL_W'(t);
                o_match.frame     = fi[t];
                o_match.msg_bytes = bytes[t];
                o_match.frames    = nf[t];
                o_match.chunk     = chunk[t];
            end
        end
    end

endmodule

[hw/rtl/can_multi_frame_reassembler.sv]
// Top level of the CAN multi-frame reassembler: topic registers, message store,
// per-topic receive state and the word readout.
// Depends on cmfr_pkg, cmfr_frame_if, cmfr_word_if and cmfr_match.
`timescale 1ns / 1ps

// Frames beat in on i_frame and are matched against the enabled topics in index
// order; a topic owns the identifiers from its base id up to one per eight bytes
// of its message size. The matching frame's bytes are merged into the topic's
// slice of the message store and its bit is set in the topic's received mask,
// which is cleared first when frame zero arrives or when the gap since the
// topic's previous frame exceeds gap_timeout_ms. Once every frame is present,
// the message leaves on o_word as one beat per 8-byte word, the final beat
// marked by last_word. A frame that matches no topic is matched and the block
// returns to idle before the next frame can be taken. A frame that matches but
// completes nothing is matched while the store word and the topic's mask and
// time are read, then merged and written back, before the block returns to
// idle. For a completing frame, the single read port of the message store then
// streams the words out, one per cycle while the sink keeps ready high; the
// last word may still wait in the output register when the next frame is
// accepted. Storage comes up zero through per-entry valid bits, so there is no
// clearing pass after reset. Configuration writes are meant to land only while
// the block is idle.

module can_multi_frame_reassembler import cmfr_pkg::*; #(
    parameter int TOPICS        = TOPICS_DEF,
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cmfr_frame_if.sink            i_frame,
    cmfr_word_if.source           o_word
);

    // Words held per topic, and the address split of the message store.
    localparam int WPT_RAW = (MAX_MSG_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WPT     = (WPT_RAW < MAX_FRAMES) ? WPT_RAW : MAX_FRAMES;
    localparam int TW      = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam int WW      = (WPT > 1) ? $clog2(WPT) : 1;
    localparam int AW      = TW + WW;
    localparam int DEPTH   = 1 << AW;
    localparam int FW      = $clog2(MAX_FRAMES + 1);
    localparam int META_W  = MAX_FRAMES + TICK_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_UPDATE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers. Topics beyond the four setup registers stay disabled.
    logic [SETUP_W-1:0] r_setup [TOPICS];
    logic [GAP_W-1:0]   r_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TOPICS; t++) begin
                r_setup[t] <= '0;
            end
            r_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            for (int t = 0; t < TOPICS; t++) begin
                if (t < SETUP_REGS && i_cfg_idx == REG_TOPIC_SETUP0 + CFG_IDX_W'(t)) begin
                    r_setup[t] <= i_cfg_data[SETUP_W-1:0];
                end
            end
            if (i_cfg_idx == REG_GAP_TIMEOUT) begin
                r_gap <= i_cfg_data[GAP_W-1:0];
            end
        end
    end

    // The frame is captured on acceptance and matched in the following cycle.
    logic [CAN_ID_W-1:0] r_in_id;
    logic [DLC_W-1:0]    r_in_dlc;
    logic [DATA_W-1:0]   r_in_data;
    logic [TICK_W-1:0]   r_in_now;
    logic                in_fire;

    assign i_frame.ready = (r_state == S_IDLE);
    assign in_fire       = i_frame.valid && i_frame.ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_id   <= i_frame.can_id;
            r_in_dlc  <= i_frame.byte_count;
            r_in_data <= i_frame.payload;
            r_in_now  <= i_frame.now_ms;
        end
    end

    t_match match;

    cmfr_match #(
        .TOPICS       (TOPICS),
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_match (
        .i_setup     (r_setup),
        .i_can_id    (r_in_id),
        .i_byte_count(r_in_dlc),
        .o_match     (match)
    );

    // The matched topic's geometry is held from the read cycle until the
    // readout of a completed message has finished.
    logic [TW-1:0]          r_topic;
    logic [FRAME_SEL_W-1:0] r_fi;
    logic [MSG_BYTES_W-1:0] r_bytes;
    logic [FW-1:0]          r_nf;
    logic [CHUNK_W-1:0]     r_chunk;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH && match.hit) begin
            r_topic <= match.topic[TW-1:0];
            r_fi    <= match.frame;
            r_bytes <= match.msg_bytes;
            r_nf    <= match.frames[FW-1:0];
            r_chunk <= match.chunk;
        end
    end

    // Per-topic receive state: the received mask and the tick of the last frame.
    logic [META_W-1:0] r_meta [TOPICS];
    logic [TOPICS-1:0] r_meta_ok;
    logic [META_W-1:0] r_meta_rd;
    logic              r_meta_rd_ok;
    logic              meta_re;
    logic              meta_we;
    logic [META_W-1:0] meta_wdata;

    assign meta_re = (r_state == S_MATCH) && match.hit;

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[r_topic] <= meta_wdata;
        end
        if (meta_re) begin
            r_meta_rd    <= r_meta[match.topic[TW-1:0]];
            r_meta_rd_ok <= r_meta_ok[match.topic[TW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_ok <= '0;
        end else if (meta_we) begin
            r_meta_ok[r_topic] <= 1'b1;
        end
    end

    // Message store. Its one read port serves the merge read and the readout.
    logic [DATA_W-1:0] r_store [DEPTH];
    logic [DEPTH-1:0]  r_store_ok;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic              rd_en;
    logic              rd_emit;
    logic [AW-1:0]     rd_addr;
    logic              store_we;
    logic [AW-1:0]     store_waddr;
    logic [DATA_W-1:0] store_wdata;
    logic [FW-1:0]     r_emit_w;

    assign rd_en       = meta_re || rd_emit;
    assign rd_addr     = rd_emit ? {r_topic, r_emit_w[WW-1:0]} :
                                   {match.topic[TW-1:0], match.frame[WW-1:0]};
    assign store_waddr = {r_topic, r_fi[WW-1:0]};

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_waddr] <= store_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
            r_rd_ok   <= r_store_ok[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_ok <= '0;
        end else if (store_we) begin
            r_store_ok[store_waddr] <= 1'b1;
        end
    end

    // Merge and write back. An entry never written reads as zero.
    logic [DATA_W-1:0]     old_word;
    logic [MAX_FRAMES-1:0] old_mask;
    logic [TICK_W-1:0]     old_time;
    logic [TICK_W-1:0]     gap;
    logic [MAX_FRAMES-1:0] kept_mask;
    logic [MAX_FRAMES-1:0] new_mask;
    logic [MAX_FRAMES-1:0] full_mask;
    logic                  complete;

    assign old_word = r_rd_ok ? r_rd_data : '0;
    assign old_mask = r_meta_rd_ok ? r_meta_rd[META_W-1:TICK_W] : '0;
    assign old_time = r_meta_rd_ok ? r_meta_rd[TICK_W-1:0] : '0;
    assign gap      = r_in_now - old_time;

    always_comb begin
        kept_mask = old_mask;
        // A stale partial message is dropped, and frame zero always starts afresh.
        if ((old_mask != '0) && (gap > {{(TICK_W - GAP_W){1'b0}}, r_gap})) begin
            kept_mask = '0;
        end
        if (r_fi == '0) begin
            kept_mask = '0;
        end
        new_mask = kept_mask | (MAX_FRAMES'(1) << r_fi);
        for (int f = 0; f < MAX_FRAMES; f++) begin
            full_mask[f] = (FW'(f) < r_nf);
        end
        for (int b = 0; b < WORD_BYTES; b++) begin
            store_wdata[8*b +: 8] = (CHUNK_W'(b) < r_chunk) ? r_in_data[8*b +: 8] :
                                                             old_word[8*b +: 8];
        end
    end

    assign complete   = (new_mask == full_mask);
    assign store_we   = (r_state == S_UPDATE);
    assign meta_we    = (r_state == S_UPDATE);
    assign meta_wdata = {complete ? {MAX_FRAMES{1'b0}} : new_mask, r_in_now};

    // Readout: the store's read register is the first stage, the output register
    // the second; the read register holds its word while the output stalls.
    logic                   r_s1_vld;
    logic [FW-1:0]          r_s1_w;
    logic                   out_load;
    logic                   words_left;
    logic [MSG_BYTES_W-1:0] word_rem;
    logic [DLC_W-1:0]       word_bytes;
    logic [DATA_W-1:0]      word_data;

    logic                   r_out_vld;
    logic [OUT_TOPIC_W-1:0] r_out_topic;
    logic [OUT_WORD_W-1:0]  r_out_w;
    logic [DATA_W-1:0]      r_out_data;
    logic [DLC_W-1:0]       r_out_bytes;
    logic                   r_out_last;

    assign words_left = (r_emit_w < r_nf);
    assign out_load   = r_s1_vld && (!r_out_vld || o_word.ready);
    assign rd_emit    = (r_state == S_EMIT) && words_left && (!r_s1_vld || out_load);
    assign word_rem   = r_bytes - (MSG_BYTES_W'(r_s1_w) << 3);
    assign word_bytes = (word_rem >= MSG_BYTES_W'(WORD_BYTES)) ? DLC_W'(WORD_BYTES) :
                                                                word_rem[DLC_W-1:0];

    always_comb begin
        for (int b = 0; b < WORD_BYTES; b++) begin
            word_data[8*b +: 8] = (r_rd_ok && DLC_W'(b) < word_bytes) ? r_rd_data[8*b +: 8] :
                                                                     8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_w  <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_UPDATE) begin
                r_emit_w <= '0;
            end else if (rd_emit) begin
                r_emit_w <= r_emit_w + 1'b1;
            end
            if (rd_emit) begin
                r_s1_vld <= 1'b1;
            end else if (out_load) begin
                r_s1_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_word.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_emit) begin
            r_s1_w <= r_emit_w;
        end
        if (out_load) begin
            r_out_topic <= OUT_TOPIC_W'(r_topic);
            r_out_w     <= OUT_WORD_W'(r_s1_w);
            r_out_data  <= word_data;
            r_out_bytes <= word_bytes;
            r_out_last  <= (r_s1_w + 1'b1 == r_nf);
        end
    end

    assign o_word.valid       = r_out_vld;
    assign o_word.topic_index = r_out_topic;
    assign o_word.word_index  = r_out_w;
    assign o_word.word_data   = r_out_data;
    assign o_word.word_bytes  = r_out_bytes;
    assign o_word.last_word   = r_out_last;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = match.hit ? S_UPDATE : S_IDLE;
            end
            S_UPDATE: begin
                n_state = complete ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!words_left && !r_s1_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A word in the read stage belongs to a readout in progress.
    a_s1_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == S_EMIT))
        else $error("read stage holds a word outside the readout");

    // The merge cycle always follows the read of the same frame.
    a_update_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> ($past(r_state) == S_MATCH))
        else $error("merge without a preceding store read");

    // A completed message starts its readout at word zero.
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && complete) |=> (r_state == S_EMIT && r_emit_w == '0))
        else $error("readout did not start at word zero");

    // Readout never reads past the end of the message.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_nf != '0 && r_emit_w <= r_nf))
        else $error("readout word counter out of range");

endmodule
